@@ rtl/tdts_pkg.sv @@
// ============================================================================
// Task scheduler package
// Shared types, constants and policy codes for the tick-driven scheduler.
// ============================================================================
package tdts_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TickBits   = 16;
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);
  localparam logic [7:0]  QuantumReset = 8'd10;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_RR   = 2'd1,
    POL_PRIO = 2'd2,
    POL_SRT  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    CFG_POLICY  = 2'd0,
    CFG_QUANTUM = 2'd1,
    CFG_TOTAL   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       arrival_valid;
    logic [7:0] task_id;
    logic [7:0] burst_ticks;
    logic [3:0] task_priority;
  } in_item_t;

  typedef struct packed {
    logic        done_valid;
    logic [7:0]  done_id;
    logic [7:0]  done_burst;
    logic [15:0] start_stamp;
    logic [15:0] end_stamp;
    logic [15:0] turnaround;
    logic        running_valid;
    logic [7:0]  running_id;
    logic        arrival_dropped;
    logic        all_done;
  } out_item_t;

  // One queue entry.
  typedef struct packed {
    logic [7:0]          id;
    logic [7:0]          burst;
    logic [3:0]          prio;
    logic [TickBits-1:0] start;
    logic [7:0]          ran;
  } slot_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic shift;   // take the neighbour above (pop / rotate)
    logic inc0;    // front cell adds one to its run count
  } cell_ctl_t;

  function automatic logic [8:0] key_of(input slot_t s, input logic [1:0] pol);
    if (pol == POL_PRIO) return {5'd0, s.prio};
    return {1'b0, s.burst - s.ran};
  endfunction

endpackage

@@ rtl/tdts_cell.sv @@
// ============================================================================
// Scheduler queue cell
// Holds one entry; loads, shifts towards the front or takes the entry below.
// ============================================================================
module tdts_cell (
  input  logic                clk_i,
  input  tdts_pkg::cell_ctl_t ctl_i,
  input  logic                is_front_i,
  input  logic                load_i,
  input  tdts_pkg::slot_t     load_slot_i,
  input  tdts_pkg::slot_t     above_i,   // neighbour nearer the back
  input  tdts_pkg::slot_t     below_i,   // neighbour nearer the front
  input  logic                take_below_i,
  output tdts_pkg::slot_t     slot_o
);
  tdts_pkg::slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_slot_i;
    end else if (ctl_i.shift) begin
      slot_d = above_i;
    end else if (take_below_i) begin
      slot_d = below_i;
    end else if (ctl_i.inc0 && is_front_i) begin
      slot_d.ran = slot_q.ran + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;
endmodule

@@ rtl/tick_driven_task_scheduler.sv @@
// ============================================================================
// Tick-driven task scheduler
// Ready queue as a row of cells with FCFS, round-robin, priority and SRT.
// ============================================================================
// Channel  | Handshake                  | Payload
// in       | in_valid_i / in_ready_o    | in_data_i  (tdts_pkg::in_item_t)
// out      | out_valid_o / out_ready_i  | out_data_o (tdts_pkg::out_item_t)
// cfg      | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// A tick runs from one acceptance to the next through the accepting idle state,
// a completion check, a run step and a result step. A round-robin rotation
// adds a spin step. Under priority or shortest remaining, a completion that
// leaves two or more entries adds a scan of the entries behind the front
// (up to 14), one entry a cycle, then a step that moves the minimum to the front.
// A waiting result holds the input off. Reset clears all counters.
module tick_driven_task_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tdts_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tdts_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  localparam int unsigned D  = tdts_pkg::QueueDepth;
  localparam int unsigned CB = tdts_pkg::CntBits;
  localparam int unsigned IB = $clog2(D);
  localparam int unsigned TW = tdts_pkg::TickBits;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_MOVE  = 7'b0001000,
    ST_RUN   = 7'b0010000,
    ST_SPIN  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]  policy_q;
  logic [7:0]  quantum_q;
  logic [15:0] total_q;
  logic [CB-1:0] count_q, count_d;
  logic [TW-1:0] tick_q;
  logic [8:0]  slice_q, slice_d;
  logic [15:0] done_cnt_q, done_cnt_d;
  logic [CB-1:0] pass_q, pass_d;
  logic [IB-1:0] best_idx_q, best_idx_d;
  logic [8:0]  best_key_q, best_key_d;
  tdts_pkg::out_item_t res_q, res_d;
  logic out_valid_q;
  logic dropped_q, dropped_d;

  tdts_pkg::slot_t slots [D];
  tdts_pkg::slot_t above [D];
  tdts_pkg::slot_t below [D];
  logic take_dn [D];
  logic load_en [D];
  tdts_pkg::slot_t new_slot;
  tdts_pkg::slot_t ld_slot;
  tdts_pkg::slot_t scan_slot;
  logic [8:0] scan_key;
  tdts_pkg::cell_ctl_t ctl;
  logic accept;
  logic front_fin;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= tdts_pkg::POL_FCFS;
      quantum_q <= tdts_pkg::QuantumReset;
      total_q   <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdts_pkg::CFG_POLICY:  policy_q  <= cfg_data_i[1:0];
        tdts_pkg::CFG_QUANTUM: quantum_q <= cfg_data_i[7:0];
        tdts_pkg::CFG_TOTAL:   total_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign new_slot = '{id: in_data_i.task_id, burst: in_data_i.burst_ticks,
                      prio: in_data_i.task_priority, start: tick_q, ran: 8'd0};

  // Front-cell view.
  assign front_fin = (count_q != '0) && (slots[0].ran >= slots[0].burst);

  // The minimum search reads one entry a cycle.
  assign scan_slot = slots[pass_q[IB-1:0]];
  assign scan_key  = tdts_pkg::key_of(scan_slot, policy_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    slice_d    = slice_q;
    done_cnt_d = done_cnt_q;
    pass_d     = pass_q;
    best_idx_d = best_idx_q;
    best_key_d = best_key_q;
    res_d      = res_q;
    dropped_d  = dropped_q;
    ctl        = '{shift: 1'b0, inc0: 1'b0};
    ld_slot    = new_slot;
    for (int i = 0; i < D; i++) load_en[i] = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dropped_d = 1'b0;
          if (in_data_i.arrival_valid) begin
            if (count_q < CB'(D)) begin
              load_en[count_q[IB-1:0]] = 1'b1;
              count_d = count_q + CB'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_d = '0;
        res_d.arrival_dropped = dropped_q;
        if (front_fin) begin
          res_d.done_valid  = 1'b1;
          res_d.done_id     = slots[0].id;
          res_d.done_burst  = slots[0].burst;
          res_d.start_stamp = 16'(slots[0].start);
          res_d.end_stamp   = 16'(tick_q);
          res_d.turnaround  = 16'(tick_q - slots[0].start);
          if (done_cnt_q != 16'hFFFF) done_cnt_d = done_cnt_q + 16'd1;
          slice_d   = 9'd0;
          ctl.shift = 1'b1;
          count_d   = count_q - CB'(1);
          if ((policy_q == tdts_pkg::POL_PRIO || policy_q == tdts_pkg::POL_SRT) &&
              count_q > CB'(2)) begin
            // The entry behind the front becomes the first candidate.
            pass_d     = CB'(1);
            best_idx_d = '0;
            best_key_d = tdts_pkg::key_of(slots[1], policy_q);
            state_d    = ST_SCAN;
          end else begin
            state_d = ST_RUN;
          end
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_SCAN: begin
        // A strictly smaller key wins, so the entry nearest the front wins a tie.
        if (scan_key < best_key_q) begin
          best_idx_d = pass_q[IB-1:0];
          best_key_d = scan_key;
        end
        pass_d = pass_q + CB'(1);
        if (pass_q + CB'(1) >= count_q) state_d = ST_MOVE;
      end
      ST_MOVE: begin
        // The minimum goes to the front and the entries before it step back.
        if (best_idx_q != '0) begin
          load_en[0] = 1'b1;
          ld_slot    = slots[best_idx_q];
        end
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (count_q != '0 && slots[0].ran < slots[0].burst) begin
          if (policy_q == tdts_pkg::POL_RR && slice_q > {1'b0, quantum_q}) begin
            ctl.shift = 1'b1;
            load_en[count_q[IB-1:0] - IB'(1)] = 1'b1;
            ld_slot = slots[0];
            slice_d = 9'd1;
            state_d = ST_SPIN;
          end else begin
            if (policy_q == tdts_pkg::POL_RR) slice_d = slice_q + 9'd1;
            ctl.inc0 = 1'b1;
            res_d.running_valid = 1'b1;
            res_d.running_id    = slots[0].id;
            state_d = ST_OUT;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SPIN: begin
        // After a rotation the new front runs whatever its run count.
        ctl.inc0 = 1'b1;
        res_d.running_valid = 1'b1;
        res_d.running_id    = slots[0].id;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_d.all_done = (done_cnt_q >= total_q);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      tick_q      <= '0;
      slice_q     <= '0;
      done_cnt_q  <= '0;
      pass_q      <= '0;
      best_idx_q  <= '0;
      best_key_q  <= '0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      done_cnt_q <= done_cnt_d;
      pass_q     <= pass_d;
      best_idx_q <= best_idx_d;
      best_key_q <= best_key_d;
      dropped_q  <= dropped_d;
      slice_q    <= slice_d;
      if (state_q == ST_OUT) tick_q <= tick_q + TW'(1);
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Wiring of the row.
  for (genvar g = 0; g < D; g++) begin : g_cell
    assign above[g]   = (g == D - 1) ? slots[g] : slots[(g + 1) % D];
    assign below[g]   = (g == 0) ? slots[g] : slots[(g + D - 1) % D];
    assign take_dn[g] = (state_q == ST_MOVE) && (g != 0) && (IB'(g) <= best_idx_q);

    tdts_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .is_front_i  (g == 0),
      .load_i      (load_en[g]),
      .load_slot_i (ld_slot),
      .above_i     (above[g]),
      .below_i     (below[g]),
      .take_below_i(take_dn[g]),
      .slot_o      (slots[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;
endmodule

@@ rtl/tdts_checker.sv @@
// ============================================================================
// Scheduler port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
module tdts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tdts_pkg::out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // An accepted transaction is processed before the next is taken.
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_valid |-> out_data_o.turnaround == 16'd0)
    else $error("turnaround without completion");

  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.turnaround ==
      16'(out_data_o.end_stamp - out_data_o.start_stamp))
    else $error("turnaround mismatch");

  a_run_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.running_valid |-> out_data_o.running_id == 8'd0)
    else $error("running id without run");
endmodule

bind tick_driven_task_scheduler tdts_checker u_tdts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
